[rtl/dxt_pkg.sv]
// Shared types, constants and palette arithmetic for the DXT block decoder.
package dxt_pkg;

   localparam logic [1:0] MODE_COLOR    = 2'd0;
   localparam logic [1:0] MODE_EXPLICIT = 2'd1;
   localparam logic [1:0] MODE_INTERP   = 2'd2;

   localparam int PIXELS = 16;
   localparam logic [3:0] LAST_PIXEL = 4'(PIXELS - 1);
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef logic [3:0][31:0] color_pal_type;
   typedef logic [7:0][7:0] alpha_pal_type;

   // Exact for x below 768.
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   // Exact for x below 1792.
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

   // Exact for x below 1280.
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd1639;
      return p[20:13];
   endfunction

   function automatic logic [31:0] pack_argb(input logic [7:0] a, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
      return {a, r, g, b};
   endfunction

endpackage

[rtl/dxt_palette.sv]
// Color and alpha palette construction for one held block.
module dxt_palette (
   input  logic [63:0]           color_block,
   input  logic [63:0]           alpha_block,
   output dxt_pkg::color_pal_type color_pal,
   output dxt_pkg::alpha_pal_type alpha_pal
);
   import dxt_pkg::*;

   logic [15:0] c0, c1;
   logic [7:0]  r0, g0, b0, r1, g1, b1;
   logic [7:0]  a0, a1;

   assign c0 = color_block[15:0];
   assign c1 = color_block[31:16];
   assign r0 = {c0[15:11], 3'b000};
   assign g0 = {c0[10:5], 2'b00};
   assign b0 = {c0[4:0], 3'b000};
   assign r1 = {c1[15:11], 3'b000};
   assign g1 = {c1[10:5], 2'b00};
   assign b1 = {c1[4:0], 3'b000};
   assign a0 = alpha_block[7:0];
   assign a1 = alpha_block[15:8];

   always_comb begin
      color_pal[0] = pack_argb(ALPHA_OPAQUE, r0, g0, b0);
      color_pal[1] = pack_argb(ALPHA_OPAQUE, r1, g1, b1);
      if (c0 > c1) begin
         color_pal[2] = pack_argb(ALPHA_OPAQUE,
                                  div3({1'b0, r0, 1'b0} + 10'(r1)),
                                  div3({1'b0, g0, 1'b0} + 10'(g1)),
                                  div3({1'b0, b0, 1'b0} + 10'(b1)));
         color_pal[3] = pack_argb(ALPHA_OPAQUE,
                                  div3(10'(r0) + {1'b0, r1, 1'b0}),
                                  div3(10'(g0) + {1'b0, g1, 1'b0}),
                                  div3(10'(b0) + {1'b0, b1, 1'b0}));
      end else begin
         color_pal[2] = pack_argb(ALPHA_OPAQUE,
                                  8'((9'(r0) + 9'(r1)) >> 1),
                                  8'((9'(g0) + 9'(g1)) >> 1),
                                  8'((9'(b0) + 9'(b1)) >> 1));
         color_pal[3] = '0;
      end
   end

   always_comb begin
      alpha_pal[0] = a0;
      alpha_pal[1] = a1;
      if (a0 > a1) begin
         for (int k = 2; k < 8; k++) begin
            alpha_pal[k] = div7(11'(a0) * 11'(8 - k) + 11'(a1) * 11'(k - 1));
         end
      end else begin
         for (int k = 2; k < 6; k++) begin
            alpha_pal[k] = div5(11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k - 1));
         end
         alpha_pal[6] = 8'd0;
         alpha_pal[7] = 8'd255;
      end
   end

endmodule

[rtl/dxt_block_decoder.sv]
// Top level of the DXT1/3/5 block decoder: block register, pixel sequencing, result register.
//
//   channel   direction  ports                                    moves
//   request   in         req_valid/ready, color_block, alpha_block one compressed block
//   response  out        rsp_valid/ready, pixel_index, argb, last  one decoded pixel
//   csr       in         csr_wr_en, csr_wr_data                    format mode
//
// The result register emits one pixel per cycle from the held block unless rsp_ready stalls it.
// The next block is taken while the sixteenth pixel moves out, so blocks follow with no gap.
// Reset clears the format mode, the block and result valid flags and the pixel count.
// A stall on rsp_ready holds the result register and the pixel count; requests then wait while a block is held.
module dxt_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_color_block,
   input  logic [63:0] req_alpha_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_pixel_index,
   output logic [31:0] rsp_argb,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import dxt_pkg::*;

   logic [1:0]    mode_ff;
   logic [1:0]    blk_mode_ff;
   logic [63:0]   color_ff, alpha_ff;
   logic          blk_valid_ff, blk_valid_in;
   logic [3:0]    count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_index_ff;
   logic [31:0]   rsp_argb_ff, argb_in;
   logic          rsp_last_ff;
   logic          advance, emit, accept;
   color_pal_type color_pal;
   alpha_pal_type alpha_pal;
   logic [1:0]    color_idx;
   logic [2:0]    alpha_idx;
   logic [3:0]    nibble;

   dxt_palette u_palette (
      .color_block (color_ff),
      .alpha_block (alpha_ff),
      .color_pal   (color_pal),
      .alpha_pal   (alpha_pal)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign emit      = blk_valid_ff && advance;
   assign req_ready = !blk_valid_ff || (emit && count_ff == LAST_PIXEL);
   assign accept    = req_valid && req_ready;

   assign color_idx = color_ff[32 + 2 * count_ff +: 2];
   assign alpha_idx = alpha_ff[16 + 3 * count_ff +: 3];
   assign nibble    = alpha_ff[4 * count_ff +: 4];

   always_comb begin
      argb_in = color_pal[color_idx];
      case (blk_mode_ff)
         MODE_EXPLICIT: argb_in[31:24] = {nibble, nibble};
         MODE_INTERP:   argb_in[31:24] = alpha_pal[alpha_idx];
         default:       argb_in[31:24] = color_pal[color_idx][31:24];
      endcase
   end

   always_comb begin
      blk_valid_in = blk_valid_ff;
      count_in     = count_ff;
      if (emit) begin
         count_in = count_ff + 4'd1;
         if (count_ff == LAST_PIXEL) begin
            blk_valid_in = 1'b0;
         end
      end
      if (accept) begin
         blk_valid_in = 1'b1;
         count_in     = '0;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_COLOR;
         blk_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         blk_valid_ff <= blk_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         color_ff    <= req_color_block;
         alpha_ff    <= req_alpha_block;
         blk_mode_ff <= mode_ff;
      end
      if (emit) begin
         rsp_index_ff <= count_ff;
         rsp_argb_ff  <= argb_in;
         rsp_last_ff  <= (count_ff == LAST_PIXEL);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_argb        = rsp_argb_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
